// File: hdl/marker_length_frame_deframer_core_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef MARKER_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define MARKER_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MLFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MLFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mlfd_pkg.sv
package mlfd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned PosW   = 17;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;
	localparam int unsigned TdataW = 32;

	localparam logic [PosW-1:0]  PosMax   = '1;
	localparam logic [ByteW-1:0] TypeIdle = 8'hFF;

	localparam logic [ByteW-1:0] StartMarkerARst = 8'h80;
	localparam logic [ByteW-1:0] StartMarkerBRst = 8'hC0;
	localparam logic [ByteW-1:0] EndMarkerARst   = 8'h81;
	localparam logic [ByteW-1:0] EndMarkerBRst   = 8'hC1;
	localparam logic [ByteW-1:0] PayloadTypeARst = 8'h04;
	localparam logic [ByteW-1:0] PayloadTypeBRst = 8'h10;

	typedef enum logic [2:0] {
		REG_START_A   = 3'd0,
		REG_START_B   = 3'd1,
		REG_END_A     = 3'd2,
		REG_END_B     = 3'd3,
		REG_PAYLOAD_A = 3'd4,
		REG_PAYLOAD_B = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_GOOD    = 2'd2,
		KIND_REJECT  = 2'd3
	} kind_t;

endpackage

// File: hdl/marker_length_frame_deframer_core.sv
// Length-prefixed frame deframer.
// Input stream s_*: one received byte per transaction in s_tdata[7:0].
// Output stream m_*: exactly one result per input byte. m_tuser carries the
// kind (none, payload byte, frame good, frame rejected); m_tdata carries the
// payload byte, the latched frame type and the declared length.
// Configuration: APB registers at byte addresses 0x00..0x14 hold the two
// start markers, the two end markers and the two payload frame types.
// The result of a byte appears on m_* in the cycle after its transaction.
// Throughput: one byte per cycle while results are taken, set by the single
// frame-state update between the input handshake and the result register.
// The result register frees itself in the same cycle it is taken, so
// s_tready stays high while m_tready is high; if the receiver stalls with a
// result pending, s_tready drops until that result is taken.
// Reset clears the frame state (no frame open, type latch 0xFF), loads the
// default marker and type registers and empties the result register.
// The user writes configuration only while no byte is in flight; not enforced.
module marker_length_frame_deframer_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [7:0]                              s_tdata,  // [7:0] in_byte
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// [7:0] payload_byte, [15:8] frame_kind, [31:16] declared_len
	output logic [mlfd_pkg::TdataW-1:0]             m_tdata,
	output logic [1:0]                              m_tuser,  // [1:0] kind
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [mlfd_pkg::AddrW-1:0]              paddr,
	input  logic [mlfd_pkg::DataW-1:0]              pwdata,
	output logic [mlfd_pkg::DataW-1:0]              prdata,
	output logic                                    pready
);

	`include "marker_length_frame_deframer_core_assert.svh"

	logic [7:0] start_a_q, start_b_q, end_a_q, end_b_q, ptype_a_q, ptype_b_q;

	logic                          in_frame_q;
	logic [mlfd_pkg::PosW-1:0]     pos_q;
	logic [7:0]                    type_q;
	logic [mlfd_pkg::LenW-1:0]     len_q;
	logic [mlfd_pkg::LenW-1:0]     count_q;

	logic                          out_valid_q;
	mlfd_pkg::kind_t               kind_q;
	logic [7:0]                    pbyte_q;
	logic [7:0]                    fkind_q;
	logic [mlfd_pkg::LenW-1:0]     dlen_q;

	logic                          s_acc, cfg_wr;
	logic [2:0]                    reg_idx;
	logic [7:0]                    b;
	logic                          is_start, is_end, inf, typed, close;
	logic [7:0]                    type_n;
	logic [mlfd_pkg::PosW-1:0]     pos_n;
	logic [mlfd_pkg::LenW-1:0]     len_n, count_n;
	logic [mlfd_pkg::PosW-1:0]     pay_end;
	mlfd_pkg::kind_t               kind_n;
	logic [7:0]                    pbyte_n;
	logic [mlfd_pkg::LenW-1:0]     dlen_n;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign reg_idx  = paddr[4:2];
	assign s_tready = ~out_valid_q | m_tready;
	assign s_acc    = s_tvalid & s_tready;
	assign b        = s_tdata;

	always_comb begin
		case (reg_idx)
			mlfd_pkg::REG_START_A:   prdata = {24'd0, start_a_q};
			mlfd_pkg::REG_START_B:   prdata = {24'd0, start_b_q};
			mlfd_pkg::REG_END_A:     prdata = {24'd0, end_a_q};
			mlfd_pkg::REG_END_B:     prdata = {24'd0, end_b_q};
			mlfd_pkg::REG_PAYLOAD_A: prdata = {24'd0, ptype_a_q};
			mlfd_pkg::REG_PAYLOAD_B: prdata = {24'd0, ptype_b_q};
			default:                 prdata = '0;
		endcase
	end

	always_comb begin
		is_start = (b == start_a_q) || (b == start_b_q);
		is_end   = (b == end_a_q) || (b == end_b_q);
		inf      = in_frame_q | is_start;
		type_n   = (inf && pos_q == 17'd1) ? b : type_q;
		typed    = (type_n == ptype_a_q) || (type_n == ptype_b_q);
		pay_end  = {1'b0, len_q} + 17'd5;
		len_n    = len_q;
		count_n  = count_q;
		kind_n   = mlfd_pkg::KIND_NONE;
		pbyte_n  = '0;
		dlen_n   = '0;
		pos_n    = pos_q;
		if (inf) begin
			if (typed) begin
				if (pos_q == 17'd3) begin
					len_n = {b, 8'd0};
				end else if (pos_q == 17'd4) begin
					len_n = len_q + {8'd0, b};
				end else if (pos_q > 17'd4 && pos_q < pay_end) begin
					if (count_q != '1) begin
						count_n = count_q + 16'd1;
					end
					kind_n  = mlfd_pkg::KIND_PAYLOAD;
					pbyte_n = b;
				end
			end
			if (pos_q != mlfd_pkg::PosMax) begin
				pos_n = pos_q + 17'd1;
			end
		end
		close = is_end & inf;
		if (close) begin
			kind_n  = (count_n == len_n) ? mlfd_pkg::KIND_GOOD : mlfd_pkg::KIND_REJECT;
			pbyte_n = '0;
			dlen_n  = len_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_a_q <= mlfd_pkg::StartMarkerARst;
			start_b_q <= mlfd_pkg::StartMarkerBRst;
			end_a_q   <= mlfd_pkg::EndMarkerARst;
			end_b_q   <= mlfd_pkg::EndMarkerBRst;
			ptype_a_q <= mlfd_pkg::PayloadTypeARst;
			ptype_b_q <= mlfd_pkg::PayloadTypeBRst;
		end else if (cfg_wr) begin
			case (reg_idx)
				mlfd_pkg::REG_START_A:   start_a_q <= pwdata[7:0];
				mlfd_pkg::REG_START_B:   start_b_q <= pwdata[7:0];
				mlfd_pkg::REG_END_A:     end_a_q   <= pwdata[7:0];
				mlfd_pkg::REG_END_B:     end_b_q   <= pwdata[7:0];
				mlfd_pkg::REG_PAYLOAD_A: ptype_a_q <= pwdata[7:0];
				mlfd_pkg::REG_PAYLOAD_B: ptype_b_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			type_q     <= mlfd_pkg::TypeIdle;
			len_q      <= '0;
			count_q    <= '0;
		end else if (s_acc) begin
			if (close) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				type_q     <= mlfd_pkg::TypeIdle;
				len_q      <= '0;
				count_q    <= '0;
			end else begin
				in_frame_q <= inf;
				pos_q      <= pos_n;
				type_q     <= type_n;
				len_q      <= len_n;
				count_q    <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q  <= kind_n;
			pbyte_q <= pbyte_n;
			fkind_q <= type_n;
			dlen_q  <= dlen_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {dlen_q, fkind_q, pbyte_q};

	`MLFD_ASSERT_NEXT(a_close_clears, s_acc && close, !in_frame_q && count_q == '0,
		"frame state not cleared after close")
	`MLFD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= len_q,
		"payload count exceeds declared length")
	`MLFD_ASSERT_SAME(a_verdict_no_byte,
		m_tvalid && (m_tuser == mlfd_pkg::KIND_GOOD || m_tuser == mlfd_pkg::KIND_REJECT),
		m_tdata[7:0] == 8'd0, "verdict carries a payload byte")
	`MLFD_ASSERT_SAME(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready,
		"input stalled without pending output")

endmodule
